// ===== hw/rtl/rids_pkg.sv =====
`default_nettype none
package rids_pkg;

	// Operation codes of an input word
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NEW_ID = 2'd3
	} op_t;

	// One accepted input word
	typedef struct packed {
		op_t         op;
		logic [15:0] slot_index;
		logic [31:0] record_id;
		logic        dirty;
		logic [7:0]  rec_type;
	} item_t;

	// One stored table entry
	typedef struct packed {
		logic [7:0]  rec_type;
		logic        dirty;
		logic [31:0] record_id;
		logic [15:0] key;
	} entry_t;

	// One result word
	typedef struct packed {
		logic        found;
		logic [15:0] found_index;
		logic [31:0] new_id;
		logic        status;
	} res_t;

	localparam logic [31:0] FIRST_ID = 32'd1;

endpackage
`default_nettype wire

// ===== hw/rtl/rids_mem.sv =====
`default_nettype none
module rids_mem #(
	parameter int ENTRIES = 64
) (
	input  wire                          clk,
	input  wire                          we,
	input  wire  [$clog2(ENTRIES)-1:0]   waddr,
	input  rids_pkg::entry_t             wdata,
	input  wire                          re,
	input  wire  [$clog2(ENTRIES)-1:0]   raddr,
	output rids_pkg::entry_t             rdata
);

	rids_pkg::entry_t mem [ENTRIES];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rids_seq.sv =====
`default_nettype none
module rids_seq #(
	parameter int ENTRIES = 64
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  rids_pkg::item_t                 item,
	output logic                            busy,
	output logic                            res_valid,
	input  wire                             res_take,
	output rids_pkg::res_t                  res,
	output logic [$clog2(ENTRIES+1)-1:0]    fill
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

	state_t           state_q;
	rids_pkg::item_t  item_q;
	rids_pkg::res_t   res_q;
	logic [CW-1:0]    count_q;
	logic [31:0]      last_id_q;
	logic [31:0]      cand_q;
	logic [AW-1:0]    addr_q;
	logic [CW-1:0]    issued_q;
	logic [CW-1:0]    run_q;
	logic             hit_q;
	logic [15:0]      best_q;
	logic [AW-1:0]    slot_q;
	logic             new_slot_q;
	logic             rvalid_s1;
	logic [AW-1:0]    ridx_s1;

	logic             rd_en;
	logic             wr_en;
	rids_pkg::entry_t wdata;
	rids_pkg::entry_t rec;
	logic [AW-1:0]    last_idx;
	logic [AW-1:0]    next_addr;
	logic [CW-1:0]    run_inc;
	logic             is_last;
	logic             key_hit;
	logic             id_hit;
	logic             cand_hit;
	logic             better;
	logic             full;

	rids_mem #(
		.ENTRIES(ENTRIES)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot_q),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (rec)
	);

	// Issue reads: linear over filled entries, circular for new id search
	always_comb begin
		last_idx  = AW'(count_q - CW'(1));
		next_addr = (addr_q == last_idx) ? '0 : AW'(addr_q + AW'(1));
		rd_en     = (state_q == ST_SCAN) &&
			((item_q.op == rids_pkg::OP_NEW_ID) || (issued_q < count_q));
		run_inc   = CW'(run_q + CW'(1));
		full      = (count_q == CW'(ENTRIES));
	end

	// Compare returned entry against the held word
	always_comb begin
		is_last  = (ridx_s1 == last_idx);
		key_hit  = (rec.key == item_q.slot_index);
		id_hit   = (rec.record_id == item_q.record_id);
		cand_hit = (rec.record_id == cand_q);
		better   = id_hit && (!hit_q || (rec.key < best_q));
	end

	// Build write-back entry
	always_comb begin
		wr_en          = (state_q == ST_WRITE);
		wdata.rec_type = item_q.rec_type;
		wdata.dirty    = item_q.dirty;
		wdata.record_id = item_q.record_id;
		wdata.key      = item_q.slot_index;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			item_q     <= '0;
			res_q      <= '0;
			count_q    <= '0;
			last_id_q  <= rids_pkg::FIRST_ID;
			cand_q     <= '0;
			addr_q     <= '0;
			issued_q   <= '0;
			run_q      <= '0;
			hit_q      <= 1'b0;
			best_q     <= '0;
			slot_q     <= '0;
			new_slot_q <= 1'b0;
			rvalid_s1  <= 1'b0;
			ridx_s1    <= '0;
		end else begin
			rvalid_s1 <= rd_en;
			ridx_s1   <= addr_q;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_q   <= item;
						hit_q    <= 1'b0;
						best_q   <= '0;
						run_q    <= '0;
						addr_q   <= '0;
						issued_q <= '0;
						cand_q   <= last_id_q + 32'd1;
						unique case (item.op)
							rids_pkg::OP_CLEAR: begin
								res_q     <= '0;
								count_q   <= '0;
								last_id_q <= rids_pkg::FIRST_ID;
								state_q   <= ST_DONE;
							end
							rids_pkg::OP_INSERT: begin
								res_q <= '0;
								if (count_q == '0) begin
									slot_q     <= '0;
									new_slot_q <= 1'b1;
									state_q    <= ST_WRITE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							rids_pkg::OP_LOOKUP: begin
								res_q   <= '0;
								state_q <= (count_q == '0) ? ST_DONE : ST_SCAN;
							end
							rids_pkg::OP_NEW_ID: begin
								if (count_q == '0) begin
									last_id_q <= last_id_q + 32'd1;
									res_q     <= '{found: 1'b0, found_index: 16'd0,
										new_id: last_id_q + 32'd1, status: 1'b0};
									state_q   <= ST_DONE;
								end else begin
									res_q   <= '0;
									state_q <= ST_SCAN;
								end
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						addr_q   <= next_addr;
						issued_q <= CW'(issued_q + CW'(1));
					end
					if (rvalid_s1) begin
						case (item_q.op)
							rids_pkg::OP_INSERT: begin
								if (key_hit) begin
									slot_q     <= ridx_s1;
									new_slot_q <= 1'b0;
									state_q    <= ST_WRITE;
								end else if (is_last) begin
									if (full) begin
										res_q.status <= 1'b1;
										state_q      <= ST_DONE;
									end else begin
										slot_q     <= count_q[AW-1:0];
										new_slot_q <= 1'b1;
										state_q    <= ST_WRITE;
									end
								end
							end
							rids_pkg::OP_LOOKUP: begin
								if (better) begin
									best_q <= rec.key;
									hit_q  <= 1'b1;
								end
								if (is_last) begin
									res_q.found       <= hit_q || id_hit;
									res_q.found_index <= better ? rec.key : best_q;
									state_q           <= ST_DONE;
								end
							end
							rids_pkg::OP_NEW_ID: begin
								// Advance candidate on a hit; accept after a full clean lap
								if (cand_hit) begin
									cand_q <= cand_q + 32'd1;
									run_q  <= '0;
								end else if (run_inc == count_q) begin
									last_id_q    <= cand_q;
									res_q.new_id <= cand_q;
									state_q      <= ST_DONE;
								end else begin
									run_q <= run_inc;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_WRITE: begin
					if (new_slot_q) begin
						count_q <= CW'(count_q + CW'(1));
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;
	assign fill      = count_q;

endmodule
`default_nettype wire

// ===== hw/rtl/record_id_state_table_top.sv =====
// Record id state table.
// Input channel (in_valid/in_ready) takes one word: op, slot_index, record_id,
// dirty, rec_type. Output channel (out_valid/out_ready) returns exactly one
// word per input: found, found_index, new_id, status.
// Entries live in one single-port-read memory with registered read data;
// the sequencer walks the filled entries one read per cycle.
// A lookup scans all filled entries; an insert scans until a key match or
// the last entry; a new id search laps the filled entries until one full
// lap finds no entry holding the candidate, moving to the next candidate
// on each hit. When the table is empty no scan is run.
// One word is worked on at a time.
// An output register holds a finished result, so the next word is taken
// while the receiver stalls; the sequencer waits only if it finishes again
// before the held result is taken.
// Reset empties the table at once (fill count to zero) and sets the last
// issued id to 1; no clearing pass is run.
`default_nettype none
module record_id_state_table_top #(
	parameter int ENTRIES = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  op,
	input  wire  [15:0] slot_index,
	input  wire  [31:0] record_id,
	input  wire         dirty,
	input  wire  [7:0]  rec_type,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        found,
	output logic [15:0] found_index,
	output logic [31:0] new_id,
	output logic        status
);

	localparam int CW = $clog2(ENTRIES + 1);

	rids_pkg::item_t item;
	rids_pkg::res_t  seq_res;
	rids_pkg::res_t  out_q;
	logic            out_valid_q;
	logic            seq_busy;
	logic            seq_res_valid;
	logic            res_take;
	logic            start;
	logic [CW-1:0]   fill;

	// Gather input word
	always_comb begin
		item.op         = rids_pkg::op_t'(op);
		item.slot_index = slot_index;
		item.record_id  = record_id;
		item.dirty      = dirty;
		item.rec_type   = rec_type;
	end

	assign in_ready = !seq_busy;
	assign start    = in_valid && in_ready;
	assign res_take = !out_valid_q || out_ready;

	rids_seq #(
		.ENTRIES(ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (seq_busy),
		.res_valid (seq_res_valid),
		.res_take  (res_take),
		.res       (seq_res),
		.fill      (fill)
	);

	// Hold result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (seq_res_valid && res_take) begin
			out_valid_q <= 1'b1;
			out_q       <= seq_res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = out_q.found;
	assign found_index = out_q.found_index;
	assign new_id      = out_q.new_id;
	assign status      = out_q.status;

	// Fill count never passes the table size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= CW'(ENTRIES))
		else $error("fill count above table size");

	// A dropped insert only happens on a full table
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		seq_res_valid && seq_res.status |-> fill == CW'(ENTRIES))
		else $error("insert dropped while table not full");

	// Accepting a word makes the sequencer busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("input ready right after accept");

	// A result not yet taken holds its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seq_res_valid && !res_take |=> seq_res_valid && $stable(seq_res))
		else $error("pending result changed");

endmodule
`default_nettype wire
